/* design/subpiece_presence_tracker_assert.svh */
// assertion macros for the subpiece presence tracker, used by spt_ctrl
// no dependencies; included by the files that carry assertions
`ifndef SUBPIECE_PRESENCE_TRACKER_ASSERT_SVH
`define SUBPIECE_PRESENCE_TRACKER_ASSERT_SVH

// condition must hold in the same cycle
`define SPT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spt assertion failed in %m");

// condition must hold in the next cycle
`define SPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spt assertion failed in %m");

`endif

/* design/spt_pkg.sv */
// shared types, constants and helpers for the subpiece presence tracker
// no dependencies
package spt_pkg;

  localparam int MAX_SUBPIECES_DEF       = 2048;
  localparam int SUBPIECES_PER_PIECE_DEF = 128;
  localparam int TOTAL_RESET             = 2048;

  localparam int TOTAL_W   = 12;
  localparam int SUB_W     = 11;
  localparam int PIECE_W   = 4;
  localparam int MODE_W    = 2;
  localparam int CALC_W    = 17;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_MARK  = 2'd0,
    MODE_TEST  = 2'd1,
    MODE_PIECE = 2'd2,
    MODE_FIND  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               range_error;
    logic [TOTAL_W-1:0] held_count;
    logic [SUB_W-1:0]   found_index;
    logic               found;
    logic               present;
    logic               mark_ok;
  } result_t;

  // position of the lowest set bit, 0 when none
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* design/spt_map_ram.sv */
// presence map storage: one write port, one registered read port
// depends on spt_pkg for the word width
module spt_map_ram
  import spt_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/spt_ctrl.sv */
// request sequencer: range checks, word scan over the map, held count,
// clearing pass and output register; depends on spt_pkg and the assert header
`include "subpiece_presence_tracker_assert.svh"

module spt_ctrl
  import spt_pkg::*;
#(
  parameter int MAX_SUBPIECES       = MAX_SUBPIECES_DEF,
  parameter int SUBPIECES_PER_PIECE = SUBPIECES_PER_PIECE_DEF,
  parameter int WORDS               = (MAX_SUBPIECES + WORD_BITS - 1) / WORD_BITS,
  parameter int AW                  = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TOTAL_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mode_t                in_mode,
  input  logic [SUB_W-1:0]     in_sub,
  input  logic [PIECE_W-1:0]   in_piece,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_res,
  output logic                 ram_wr_en,
  output logic [AW-1:0]        ram_wr_addr,
  output logic [WORD_BITS-1:0] ram_wr_data,
  output logic                 ram_rd_en,
  output logic [AW-1:0]        ram_rd_addr,
  input  logic [WORD_BITS-1:0] ram_rd_data
);

  localparam int POS_W = AW + BIT_W;
  localparam logic [CALC_W-1:0] MAX_C = CALC_W'(MAX_SUBPIECES);
  localparam logic [CALC_W-1:0] SPP_C = CALC_W'(SUBPIECES_PER_PIECE);
  localparam logic [TOTAL_W-1:0] TOTAL_INIT =
    TOTAL_W'((MAX_SUBPIECES < TOTAL_RESET) ? MAX_SUBPIECES : TOTAL_RESET);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

  state_t state, state_next;

  logic [AW-1:0]      clr_addr;
  logic [TOTAL_W-1:0] eff_total;
  logic [TOTAL_W-1:0] held_total;
  mode_t              op_mode;
  logic [POS_W-1:0]   start_pos;
  logic [POS_W-1:0]   last_pos;
  logic [AW-1:0]      issue_word;
  logic               issue_more;
  logic [AW-1:0]      ev_word;
  logic               pend;
  result_t            res;
  result_t            res_init;
  result_t            res_out;

  logic cfg_take;
  logic in_take;
  logic out_load;

  // request decode
  logic [CALC_W-1:0]  tot_c;
  logic [CALC_W-1:0]  sub_c;
  logic [CALC_W-1:0]  piece_first;
  logic [CALC_W-1:0]  piece_end_raw;
  logic [CALC_W-1:0]  piece_end;
  logic [CALC_W-1:0]  req_first;
  logic [CALC_W-1:0]  req_last;
  logic               req_err;
  logic [TOTAL_W-1:0] cfg_total;

  // word evaluation
  logic [AW-1:0]        start_word;
  logic [AW-1:0]        last_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] miss;
  logic                 ev_last;
  logic                 ev_done;
  logic                 ev_write;
  logic                 ev_present;
  logic                 ev_found;

  assign cfg_take = cfg_valid && cfg_ready;
  assign in_take  = in_valid && in_ready;

  // a total of zero acts as one, above the map size it saturates
  always_comb begin
    cfg_total = cfg_data;
    if (cfg_data == '0) begin
      cfg_total = TOTAL_W'(1);
    end else if (CALC_W'(cfg_data) > MAX_C) begin
      cfg_total = TOTAL_W'(MAX_SUBPIECES);
    end
  end

  always_comb begin
    tot_c         = CALC_W'(eff_total);
    sub_c         = CALC_W'(in_sub);
    piece_first   = CALC_W'(in_piece) * SPP_C;
    piece_end_raw = piece_first + SPP_C;
    piece_end     = (piece_end_raw > tot_c) ? tot_c : piece_end_raw;
    case (in_mode)
      MODE_PIECE: begin
        req_err   = piece_first >= tot_c;
        req_first = piece_first;
        req_last  = piece_end - CALC_W'(1);
      end
      MODE_FIND: begin
        req_err   = sub_c >= tot_c;
        req_first = sub_c;
        req_last  = tot_c - CALC_W'(1);
      end
      default: begin
        req_err   = sub_c >= tot_c;
        req_first = sub_c;
        req_last  = sub_c;
      end
    endcase
  end

  assign start_word = start_pos[POS_W-1:BIT_W];
  assign last_word  = last_pos[POS_W-1:BIT_W];

  always_comb begin
    lo_bit  = (ev_word == start_word) ? start_pos[BIT_W-1:0] : '0;
    hi_bit  = (ev_word == last_word) ? last_pos[BIT_W-1:0] : {BIT_W{1'b1}};
    mask    = ({WORD_BITS{1'b1}} << lo_bit) &
              ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
    miss    = ~ram_rd_data & mask;
    ev_last = ev_word == last_word;
  end

  always_comb begin
    ev_done    = 1'b0;
    ev_write   = 1'b0;
    ev_present = 1'b0;
    ev_found   = 1'b0;
    if (state == ST_SCAN && pend) begin
      case (op_mode)
        MODE_MARK: begin
          ev_done  = 1'b1;
          ev_write = miss != '0;
        end
        MODE_TEST: begin
          ev_done    = 1'b1;
          ev_present = miss == '0;
        end
        MODE_PIECE: begin
          ev_done    = (miss != '0) || ev_last;
          ev_present = miss == '0;
        end
        MODE_FIND: begin
          ev_done  = (miss != '0) || ev_last;
          ev_found = miss != '0;
        end
        default: begin
          ev_done = 1'b1;
        end
      endcase
    end
  end

  assign out_load = state == ST_DONE && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          state_next = req_err ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ev_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    if (cfg_take) begin
      state_next = ST_CLEAR;
    end
  end

  // outputs of the sequencer
  always_comb begin
    cfg_ready   = 1'b1;
    in_ready    = state == ST_IDLE;
    ram_rd_en   = state == ST_SCAN && issue_more;
    ram_rd_addr = issue_word;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ev_word;
    ram_wr_data = ram_rd_data | (WORD_BITS'(1) << start_pos[BIT_W-1:0]);
    case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      ST_SCAN: begin
        ram_wr_en = ev_write;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      eff_total  <= TOTAL_INIT;
      held_total <= '0;
      issue_more <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_take) begin
        clr_addr <= '0;
      end else if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end

      if (cfg_take) begin
        eff_total  <= cfg_total;
        held_total <= '0;
      end else if (ev_write) begin
        held_total <= held_total + TOTAL_W'(1);
      end

      if (in_take) begin
        issue_more <= ~req_err;
        pend       <= 1'b0;
      end else if (ram_rd_en) begin
        pend <= 1'b1;
        if (issue_word == last_word) begin
          issue_more <= 1'b0;
        end
      end else begin
        pend <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // fresh result on accept, and the held count joins it on the way out
  always_comb begin
    res_init             = '0;
    res_init.range_error = req_err;
    res_out              = res;
    res_out.held_count   = held_total;
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_mode    <= in_mode;
      start_pos  <= req_first[POS_W-1:0];
      last_pos   <= req_last[POS_W-1:0];
      issue_word <= req_first[POS_W-1:BIT_W];
      res        <= res_init;
    end else begin
      if (ram_rd_en) begin
        ev_word    <= issue_word;
        issue_word <= issue_word + AW'(1);
      end
      if (ev_done) begin
        res.mark_ok <= ev_write;
        res.present <= ev_present;
        res.found   <= ev_found;
        if (ev_found) begin
          res.found_index <= SUB_W'({ev_word, lowest_set(miss)});
        end
      end
    end
    if (out_load) begin
      out_res <= res_out;
    end
  end

  `SPT_ASSERT_NOW(a_held_bound, clk, rst, 1'b1, held_total <= eff_total)
  `SPT_ASSERT_NEXT(a_mark_counts, clk, rst, state == ST_SCAN && ram_wr_en && !cfg_valid, held_total == $past(held_total) + TOTAL_W'(1))
  `SPT_ASSERT_NOW(a_err_clean, clk, rst, out_valid && out_res.range_error, !out_res.mark_ok && !out_res.present && !out_res.found)
  `SPT_ASSERT_NEXT(a_accept_moves, clk, rst, in_valid && in_ready && !cfg_valid, state == ST_SCAN || state == ST_DONE)

endmodule

/* design/subpiece_presence_tracker.sv */
// Subpiece presence tracker, top level.
// Keeps a one-bit-per-subpiece map in a 64-bit-wide memory plus a held count.
// Request channel s_*: s_tuser carries the mode (mark, test subpiece, test
// piece complete, find next missing), s_tdata the subpiece and piece index.
// Result channel m_*: one result per request, in request order.
// Configuration channel cfg_*: writes total_subpieces and restarts the block,
// which clears the map and the held count.
// Map reads: a request whose index is out of range is answered without reading
// the map; otherwise the block reads map words, one per cycle on the memory
// read port: 1 for mark and test, SUBPIECES_PER_PIECE/64 at most when that
// divides evenly (2 by default) for the piece test and up to MAX_SUBPIECES/64
// rounded up (32 by default) for find-next.
// One request is worked on at a time; the next is taken once the current
// result has moved into the output register.
// After reset and after each configuration write a clearing pass zeroes the
// map, one word per cycle; no request is taken then.
// If m_tready stays low the result waits in the output register and one
// further request can be accepted and worked on behind it.
// Depends on spt_pkg, spt_map_ram and spt_ctrl.
module subpiece_presence_tracker
  import spt_pkg::*;
#(
  parameter int MAX_SUBPIECES       = MAX_SUBPIECES_DEF,
  parameter int SUBPIECES_PER_PIECE = SUBPIECES_PER_PIECE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,   // total_subpieces
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // sub_idx[10:0], pc_idx[14:11], zero pad
  input  logic [1:0]  s_tuser,    // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata     // mark_ok, present, found, found_index[13:3],
                                  // held_count[25:14], range_error[26], zero pad
);

  localparam int WORDS = (MAX_SUBPIECES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [WORD_BITS-1:0] ram_rd_data;
  result_t              res;

  spt_map_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  spt_ctrl #(
    .MAX_SUBPIECES       (MAX_SUBPIECES),
    .SUBPIECES_PER_PIECE (SUBPIECES_PER_PIECE),
    .WORDS               (WORDS),
    .AW                  (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (mode_t'(s_tuser)),
    .in_sub      (s_tdata[10:0]),
    .in_piece    (s_tdata[14:11]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  assign m_tdata = {5'b0, res.range_error, res.held_count, res.found_index,
                    res.found, res.present, res.mark_ok};

endmodule
